/* src/lfid_pkg.sv */
package lfid_pkg;

  // Command codes carried by an input item
  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Fixed field widths
  localparam int ID_W     = 6;
  localparam int OUT_H_W  = 32;
  localparam int MAX_SPAN = 64;
  localparam int GRP_W    = 8;
  localparam int GRP_IW   = 3;

  // Status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the item and read the store
    logic exec;   // apply the command and register the result
  } ctrl_t;

endpackage

/* src/lowest_free_id_handle_table_unit.sv */
// Lowest-free ID handle table.
// Input channel: an item (in_command, in_slot_id, in_handle) is taken at a
// rising edge where start is high and busy is low. Put stores a nonzero handle
// at the lowest free ID, get reads the handle at in_slot_id, remove frees it.
// Result channel: every item gives one result (out_result_id,
// out_result_handle, out_status) held for exactly one cycle and marked by
// out_strobe; the receiver cannot stall it.
// Timing: the cycle after the accept edge is the execute cycle (busy high);
// the result shows on the cycle after that, in which start is taken again.
// The block takes no new item until the execute cycle is over. The execute
// cycle is needed because the store's read port and the free-slot summary
// are registered, and both need the cycle before execute.
// Only IDs below min(ENTRIES, 64) are used; the store is that deep.
// Reset (rst_n low, synchronous) clears the occupancy map at once, so every
// ID reads as empty right away; no clearing pass is needed.
module lowest_free_id_handle_table_unit #(
  parameter int ENTRIES     = 64,
  parameter int HANDLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_command,
  input  logic [lfid_pkg::ID_W-1:0]     in_slot_id,
  input  logic [lfid_pkg::OUT_H_W-1:0]  in_handle,
  output logic                          out_strobe,
  output logic [lfid_pkg::ID_W-1:0]     out_result_id,
  output logic [lfid_pkg::OUT_H_W-1:0]  out_result_handle,
  output logic                          out_status
);

  localparam int SPAN = (ENTRIES < lfid_pkg::MAX_SPAN) ? ENTRIES : lfid_pkg::MAX_SPAN;
  localparam int SW   = (HANDLE_BITS < lfid_pkg::OUT_H_W) ? HANDLE_BITS : lfid_pkg::OUT_H_W;

  lfid_pkg::ctrl_t ctrl;

  // Controller
  lfid_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // Datapath
  lfid_dpath #(
    .SPAN (SPAN),
    .SW   (SW)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .in_command        (in_command),
    .in_slot_id        (in_slot_id),
    .in_handle         (in_handle),
    .out_strobe        (out_strobe),
    .out_result_id     (out_result_id),
    .out_result_handle (out_result_handle),
    .out_status        (out_status)
  );

  // An accepted item enters execute next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && ctrl.exec))
    else $error("accepted item did not enter execute");

  // Execute lasts one cycle and is followed by exactly one result
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.exec |=> (out_strobe && !busy))
    else $error("execute not followed by a single result");

  // No load while an item is in execute
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !ctrl.load)
    else $error("item loaded while busy");

  // A full report carries zero id and handle
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status) |-> (out_result_id == '0 && out_result_handle == '0))
    else $error("full status with nonzero payload");

endmodule

/* src/lfid_ctrl.sv */
module lfid_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output lfid_pkg::ctrl_t ctrl
);

  lfid_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfid_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ctrl.load = 1'b0;
    ctrl.exec = 1'b0;
    busy      = 1'b0;
    case (state_r)
      lfid_pkg::ST_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          state_nxt = lfid_pkg::ST_EXEC;
        end
      end
      lfid_pkg::ST_EXEC: begin
        busy      = 1'b1;
        ctrl.exec = 1'b1;
        state_nxt = lfid_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lfid_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/lfid_dpath.sv */
module lfid_dpath #(
  parameter int SPAN = 64,
  parameter int SW   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lfid_pkg::ctrl_t               ctrl,
  input  logic [1:0]                    in_command,
  input  logic [lfid_pkg::ID_W-1:0]     in_slot_id,
  input  logic [lfid_pkg::OUT_H_W-1:0]  in_handle,
  output logic                          out_strobe,
  output logic [lfid_pkg::ID_W-1:0]     out_result_id,
  output logic [lfid_pkg::OUT_H_W-1:0]  out_result_handle,
  output logic                          out_status
);

  localparam int IW  = $clog2(SPAN);
  localparam int NG  = (SPAN + lfid_pkg::GRP_W - 1) / lfid_pkg::GRP_W;
  localparam int PADW = NG * lfid_pkg::GRP_W;

  // Handle store; occupancy bits gate every read
  logic [SW-1:0] mem [SPAN];
  logic [SW-1:0] rd_data_r;

  logic [SPAN-1:0] map_r, map_nxt;

  // Captured item
  lfid_pkg::cmd_t            cmd_r;
  logic [lfid_pkg::ID_W-1:0] id_r;
  logic [SW-1:0]             h_r;

  // Registered free-slot summary, one entry per group of eight IDs
  logic [NG-1:0]                  grp_free_r;
  logic [lfid_pkg::GRP_IW-1:0]    grp_idx_r [NG];
  logic [PADW-1:0]                map_pad;

  // Result registers
  logic                          strobe_r;
  logic [lfid_pkg::ID_W-1:0]     res_id_r, res_id_nxt;
  logic [lfid_pkg::OUT_H_W-1:0]  res_h_r, res_h_nxt;
  logic                          res_st_r, res_st_nxt;

  logic                          found;
  logic [lfid_pkg::ID_W-1:0]     free_id;
  logic                          in_span;
  logic                          wr_en;

  // Capture the item and read the store at the slot given
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r     <= lfid_pkg::cmd_t'(in_command);
      id_r      <= in_slot_id;
      h_r       <= in_handle[SW-1:0];
      rd_data_r <= mem[in_slot_id[IW-1:0]];
    end
  end

  // Pad the map to whole groups; IDs past the span count as taken
  always_comb begin
    for (int i = 0; i < PADW; i++) begin
      map_pad[i] = (i < SPAN) ? map_r[i] : 1'b1;
    end
  end

  // First free bit inside each group, refreshed every cycle
  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      grp_free_r[g] <= ~&map_pad[g*lfid_pkg::GRP_W +: lfid_pkg::GRP_W];
      grp_idx_r[g]  <= '0;
      for (int b = lfid_pkg::GRP_W - 1; b >= 0; b--) begin
        if (!map_pad[g*lfid_pkg::GRP_W + b]) begin
          grp_idx_r[g] <= lfid_pkg::GRP_IW'(b);
        end
      end
    end
  end

  // Pick the lowest group that has a free ID
  always_comb begin
    found   = |grp_free_r;
    free_id = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_free_r[g]) begin
        free_id = lfid_pkg::ID_W'(g * lfid_pkg::GRP_W) |
                  lfid_pkg::ID_W'(grp_idx_r[g]);
      end
    end
  end

  assign in_span = ({1'b0, id_r} < (lfid_pkg::ID_W + 1)'(SPAN));

  // Apply the command
  always_comb begin
    map_nxt    = map_r;
    res_id_nxt = id_r;
    res_h_nxt  = '0;
    res_st_nxt = lfid_pkg::ST_OK;
    wr_en      = 1'b0;
    case (cmd_r)
      lfid_pkg::CMD_PUT: begin
        if (found) begin
          res_id_nxt = free_id;
          if (h_r != '0) begin
            wr_en                   = ctrl.exec;
            map_nxt[free_id[IW-1:0]] = 1'b1;
          end
        end else begin
          res_id_nxt = '0;
          res_st_nxt = lfid_pkg::ST_FULL;
        end
      end
      lfid_pkg::CMD_GET: begin
        if (in_span && map_r[id_r[IW-1:0]]) begin
          res_h_nxt = lfid_pkg::OUT_H_W'(rd_data_r);
        end
      end
      lfid_pkg::CMD_REMOVE: begin
        if (in_span) begin
          map_nxt[id_r[IW-1:0]] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Store write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[free_id[IW-1:0]] <= h_r;
    end
  end

  // Occupancy map and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctrl.exec;
      if (ctrl.exec) begin
        map_r <= map_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      res_id_r <= res_id_nxt;
      res_h_r  <= res_h_nxt;
      res_st_r <= res_st_nxt;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_result_id     = res_id_r;
  assign out_result_handle = res_h_r;
  assign out_status        = res_st_r;

endmodule
